[rtl/core/erhc_pkg.sv]
package erhc_pkg;

	localparam int ERHC_ADDR_BYTES = 6;
	localparam int OWN_MAC_W = 48;
	localparam int CFG_IDX_W = 2;
	localparam int ETYPE_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC_VALID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IPV6_MODE     = 2'd2;

	localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
	localparam logic [ETYPE_W-1:0] ETYPE_RARP = 16'h8035;
	localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [ETYPE_W-1:0] ETYPE_IPV6 = 16'h86dd;

	localparam logic [15:0] MCAST6_PREFIX = 16'h3333;

	typedef enum logic [2:0] {
		V_ARP           = 3'd0,
		V_IPV4          = 3'd1,
		V_IPV6          = 3'd2,
		V_NOT_ADDRESSED = 3'd3,
		V_UNKNOWN       = 3'd4,
		V_NO_OWN        = 3'd5,
		V_RUNT          = 3'd6
	} verdict_t;

	typedef struct packed {
		logic     group_bit;
		verdict_t verdict;
	} erhc_result_t;

	typedef struct packed {
		logic         valid;
		erhc_result_t res;
	} erhc_out_t;

endpackage

[rtl/core/ethernet_rx_header_classifier.sv]
// Ethernet receive header classifier. Frame bytes enter on s_axis, one per
// transaction, with tlast on the final byte. After 2*ADDR_BYTES+2 header
// bytes (14 by default) one verdict leaves on m_axis; a frame ending earlier
// gives a runt verdict, and payload bytes give nothing. Throughput is one
// byte per cycle: s_axis stalls only when a verdict is due while the output
// register is still full. A byte is held in the input register, where the
// header shift registers and the address/ethertype compare act on it, and
// the verdict is held in the output register. Configuration registers
// (own_mac, own_mac_valid, ipv6_mode) should be written while the block is
// idle; reset leaves ipv6_mode set and the others cleared.
module ethernet_rx_header_classifier #(
	parameter int ADDR_BYTES = erhc_pkg::ERHC_ADDR_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] frame_byte
	input  logic                           s_axis_tlast,  // frame_last
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [2:0] verdict, [3] group_bit
	input  logic                           cfg_we,
	input  logic [erhc_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [erhc_pkg::OWN_MAC_W-1:0] cfg_data
);
	import erhc_pkg::*;

	logic [OWN_MAC_W-1:0] own_mac_q;
	logic                 own_mac_valid_q;
	logic                 ipv6_mode_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic         out_valid_s2;
	erhc_result_t out_s2;

	logic      out_free;
	logic      go;
	erhc_out_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q       <= '0;
			own_mac_valid_q <= 1'b0;
			ipv6_mode_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_OWN_MAC:       own_mac_q       <= cfg_data;
				CFG_OWN_MAC_VALID: own_mac_valid_q <= cfg_data[0];
				CFG_IPV6_MODE:     ipv6_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free      = !out_valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	erhc_parser #(.ADDR_BYTES(ADDR_BYTES)) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.item_byte    (byte_s1),
		.item_last    (last_s1),
		.out_free     (out_free),
		.own_mac      (own_mac_q),
		.own_mac_valid(own_mac_valid_q),
		.ipv6_mode    (ipv6_mode_q),
		.go           (go),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (go && result.valid) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && result.valid) begin
			out_s2 <= result.res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {4'b0000, out_s2};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_s2 && !m_axis_tready))
		else $error("input stalled without a blocked verdict");

	a_group_ipv4: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] == V_IPV4))
		else $error("group bit set on a non-IPv4 verdict");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7) && (m_axis_tdata[7:4] == 4'd0))
		else $error("verdict out of range");

endmodule

[rtl/core/erhc_classify.sv]
module erhc_classify #(
	parameter int ADDR_BYTES = erhc_pkg::ERHC_ADDR_BYTES
) (
	input  logic [erhc_pkg::OWN_MAC_W-1:0] own_mac,
	input  logic                           own_mac_valid,
	input  logic                           ipv6_mode,
	input  logic [8*ADDR_BYTES-1:0]        dst,
	input  logic [8*ADDR_BYTES-1:0]        src,
	input  logic [erhc_pkg::ETYPE_W-1:0]   etype,
	output erhc_pkg::erhc_result_t         res
);
	import erhc_pkg::*;

	localparam int ADDR_W = 8 * ADDR_BYTES;

	logic [63:0]       own_wide;
	logic [ADDR_W-1:0] own;
	logic              addr_ok;
	logic              bypass;
	logic              no_own;

	// own_mac truncated or zero-extended to the address width
	assign own_wide = {{(64-OWN_MAC_W){1'b0}}, own_mac};
	assign own      = own_wide[ADDR_W-1:0];

	always_comb begin
		bypass = 1'b0;
		no_own = 1'b0;
		if (ipv6_mode) begin
			if (dst[ADDR_W-1 -: 16] == MCAST6_PREFIX) begin
				bypass = 1'b1;
			end else if (!own_mac_valid) begin
				no_own = 1'b1;
			end else if (src == own) begin
				bypass = 1'b1;
			end
		end
		addr_ok = bypass || (dst == own) || (&dst);
	end

	always_comb begin
		res.group_bit = 1'b0;
		res.verdict   = V_UNKNOWN;
		if (no_own) begin
			res.verdict = V_NO_OWN;
		end else if (!addr_ok) begin
			res.verdict = V_NOT_ADDRESSED;
		end else begin
			case (etype)
				ETYPE_ARP, ETYPE_RARP: res.verdict = V_ARP;
				ETYPE_IPV4: begin
					res.verdict   = V_IPV4;
					res.group_bit = dst[ADDR_W-8];
				end
				ETYPE_IPV6: res.verdict = ipv6_mode ? V_IPV6 : V_UNKNOWN;
				default: res.verdict = V_UNKNOWN;
			endcase
		end
	end

endmodule

[rtl/core/erhc_parser.sv]
module erhc_parser #(
	parameter int ADDR_BYTES = erhc_pkg::ERHC_ADDR_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic [7:0]                     item_byte,
	input  logic                           item_last,
	input  logic                           out_free,
	input  logic [erhc_pkg::OWN_MAC_W-1:0] own_mac,
	input  logic                           own_mac_valid,
	input  logic                           ipv6_mode,
	output logic                           go,
	output erhc_pkg::erhc_out_t            result
);
	import erhc_pkg::*;

	localparam int ADDR_W  = 8 * ADDR_BYTES;
	localparam int HDR_LEN = 2 * ADDR_BYTES + 2;
	localparam int IDX_W   = $clog2(HDR_LEN + 1);

	localparam logic [IDX_W-1:0] IDX_SRC  = IDX_W'(ADDR_BYTES);
	localparam logic [IDX_W-1:0] IDX_TYPE = IDX_W'(2 * ADDR_BYTES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HDR_LEN - 1);
	localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(HDR_LEN);

	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] dst_q;
	logic [ADDR_W-1:0] src_q;
	logic [7:0]        type_hi_q;
	erhc_result_t      cls;
	logic              at_last_hdr;
	logic              runt;

	erhc_classify #(.ADDR_BYTES(ADDR_BYTES)) u_classify (
		.own_mac      (own_mac),
		.own_mac_valid(own_mac_valid),
		.ipv6_mode    (ipv6_mode),
		.dst          (dst_q),
		.src          (src_q),
		.etype        ({type_hi_q, item_byte}),
		.res          (cls)
	);

	assign at_last_hdr = (idx_q == IDX_LAST);
	assign runt        = item_last && (idx_q < IDX_LAST);

	always_comb begin
		result.valid         = item_valid && (at_last_hdr || runt);
		result.res           = cls;
		if (runt) begin
			result.res.verdict   = V_RUNT;
			result.res.group_bit = 1'b0;
		end
	end

	assign go = item_valid && (!result.valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			dst_q     <= '0;
			src_q     <= '0;
			type_hi_q <= '0;
		end else if (go) begin
			if (item_last) begin
				idx_q     <= '0;
				dst_q     <= '0;
				src_q     <= '0;
				type_hi_q <= '0;
			end else if (idx_q < IDX_END) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q < IDX_SRC) begin
					dst_q <= {dst_q[ADDR_W-9:0], item_byte};
				end else if (idx_q < IDX_TYPE) begin
					src_q <= {src_q[ADDR_W-9:0], item_byte};
				end else if (idx_q == IDX_TYPE) begin
					type_hi_q <= item_byte;
				end
			end
		end
	end

endmodule
